@@ rtl/wnrl_pkg.sv @@
`timescale 1ns / 1ps

package wnrl_pkg;

    localparam int RULE_DEPTH_DEF = 256;

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_CLEAR  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_HIT     = 3'd2,
        ST_MISS    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    // one address/port pair of a rule, wildcard parts hold value zero
    typedef struct packed {
        logic        port_any;
        logic [15:0] port;
        logic        ip_any;
        logic [31:0] ip;
    } entry_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] key_ip;
        logic        key_ip_any;
        logic [15:0] key_port;
        logic        key_port_any;
        logic [31:0] xlat_ip;
        logic        xlat_ip_any;
        logic [15:0] xlat_port;
        logic        xlat_port_any;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] out_ip;
        logic        out_ip_any;
        logic [15:0] out_port;
        logic        out_port_any;
    } rsp_t;

    // query walking down the rule chain
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [31:0] ip;
        logic [15:0] port;
        entry_t      xlat;
    } tok_t;

endpackage

@@ rtl/wildcard_nat_rule_lookup.sv @@
`timescale 1ns / 1ps

// First-match NAT rule table built as a chain of RULE_DEPTH rule cells. An
// append or clear item is decided at acceptance and its result registered at
// once, or held while the response register is stalled. A lookup item walks
// the chain one cell per cycle; its result is registered when the query leaves
// the last cell, and no new item is taken until that result is registered. The
// earliest matching cell marks the query as hit and later cells pass it on,
// which gives insertion-order priority. Appends beyond RULE_DEPTH rules are
// dropped with a full status. There is no clearing pass after reset: rule
// storage is only read below the rule count. The response register plus a
// one-entry hold register let one more item be accepted while a result waits.
module wildcard_nat_rule_lookup #(
    parameter int RULE_DEPTH = wnrl_pkg::RULE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  wnrl_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output wnrl_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(RULE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_HOLD
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    wnrl_pkg::rsp_t         rsp_reg, rsp_next;
    wnrl_pkg::rsp_t         pend_reg, pend_next;

    logic                   req_take;
    logic                   rsp_free;
    logic                   full;
    logic                   wr_en;
    wnrl_pkg::rsp_t         imm_rsp;
    wnrl_pkg::rsp_t         tail_rsp;
    wnrl_pkg::entry_t       wr_key;
    wnrl_pkg::entry_t       wr_xlat;
    wnrl_pkg::tok_t         tok_head;
    wnrl_pkg::tok_t         tok [0:RULE_DEPTH];
    logic [RULE_DEPTH-1:0]  wr_sel;
    logic [RULE_DEPTH-1:0]  cell_on;

    function automatic wnrl_pkg::entry_t pack_entry(
        input logic [31:0] ip,
        input logic        ip_any,
        input logic [15:0] port,
        input logic        port_any
    );
        wnrl_pkg::entry_t e;
        e.ip_any   = ip_any;
        e.ip       = ip_any ? 32'd0 : ip;
        e.port_any = port_any;
        e.port     = port_any ? 16'd0 : port;
        return e;
    endfunction

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && (state_reg == S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign full      = (count_reg == CNT_W'(RULE_DEPTH));
    assign wr_en     = req_take && (req.func == wnrl_pkg::FN_APPEND) && !full;
    assign wr_key    = pack_entry(req.key_ip, req.key_ip_any, req.key_port, req.key_port_any);
    assign wr_xlat   = pack_entry(req.xlat_ip, req.xlat_ip_any, req.xlat_port,
                                  req.xlat_port_any);

    always_comb
    begin
        tok_head       = '0;
        tok_head.valid = req_take && (req.func == wnrl_pkg::FN_LOOKUP);
        tok_head.ip    = req.key_ip;
        tok_head.port  = req.key_port;
    end

    assign tok[0] = tok_head;

    genvar i;
    generate
        for (i = 0; i < RULE_DEPTH; i++)
        begin : g_cell
            assign wr_sel[i]  = wr_en && (count_reg == CNT_W'(i));
            assign cell_on[i] = (count_reg > CNT_W'(i));

            wnrl_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .wr_sel  (wr_sel[i]),
                .active  (cell_on[i]),
                .wr_key  (wr_key),
                .wr_xlat (wr_xlat),
                .tok_in  (tok[i]),
                .tok_out (tok[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        imm_rsp = '0;
        unique case (req.func)
            wnrl_pkg::FN_APPEND: imm_rsp.status = full ? wnrl_pkg::ST_FULL
                                                       : wnrl_pkg::ST_STORED;
            wnrl_pkg::FN_CLEAR:  imm_rsp.status = wnrl_pkg::ST_CLEARED;
            default:             imm_rsp.status = wnrl_pkg::ST_MISS;
        endcase
    end

    always_comb
    begin
        tail_rsp              = '0;
        tail_rsp.status       = tok[RULE_DEPTH].hit ? wnrl_pkg::ST_HIT : wnrl_pkg::ST_MISS;
        tail_rsp.out_ip       = tok[RULE_DEPTH].xlat.ip;
        tail_rsp.out_ip_any   = tok[RULE_DEPTH].xlat.ip_any;
        tail_rsp.out_port     = tok[RULE_DEPTH].xlat.port;
        tail_rsp.out_port_any = tok[RULE_DEPTH].xlat.port_any;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (req.func == wnrl_pkg::FN_CLEAR)
                    begin
                        count_next = '0;
                    end

                    if (req.func == wnrl_pkg::FN_LOOKUP)
                    begin
                        state_next = S_SEARCH;
                    end
                    else if (rsp_free)
                    begin
                        rsp_next       = imm_rsp;
                        rsp_valid_next = 1'b1;
                    end
                    else
                    begin
                        pend_next  = imm_rsp;
                        state_next = S_HOLD;
                    end
                end
            end
            S_SEARCH:
            begin
                // query leaves the last cell
                if (tok[RULE_DEPTH].valid)
                begin
                    if (rsp_free)
                    begin
                        rsp_next       = tail_rsp;
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        pend_next  = tail_rsp;
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (rsp_free)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            pend_reg      <= pend_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/wnrl_cell.sv @@
`timescale 1ns / 1ps

module wnrl_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_sel,
    input  logic             active,
    input  wnrl_pkg::entry_t wr_key,
    input  wnrl_pkg::entry_t wr_xlat,
    input  wnrl_pkg::tok_t   tok_in,
    output wnrl_pkg::tok_t   tok_out
);

    wnrl_pkg::entry_t key_reg;
    wnrl_pkg::entry_t xlat_reg;
    wnrl_pkg::tok_t   tok_reg;
    wnrl_pkg::tok_t   tok_next;
    logic             match;

    always_comb
    begin
        match = tok_in.valid && !tok_in.hit && active
            && (key_reg.ip_any || key_reg.ip == tok_in.ip)
            && (key_reg.port_any || key_reg.port == tok_in.port);
        tok_next = tok_in;
        if (match)
        begin
            tok_next.hit  = 1'b1;
            tok_next.xlat = xlat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            key_reg  <= wr_key;
            xlat_reg <= wr_xlat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ rtl/wnrl_checker.sv @@
`timescale 1ns / 1ps

module wnrl_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input wnrl_pkg::rsp_t rsp
);

    logic [1:0] outst_reg;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && !req_stall;
    assign rsp_acc = rsp_valid && !rsp_stall;

    // items accepted whose result is not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= 2'd0;
        end
        else
        begin
            outst_reg <= outst_reg + {1'b0, req_acc} - {1'b0, rsp_acc};
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != wnrl_pkg::ST_HIT |->
            rsp.out_ip == 32'd0 && !rsp.out_ip_any
            && rsp.out_port == 16'd0 && !rsp.out_port_any)
        else $error("non-hit result carries translation");

    a_wild_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.out_ip_any || rsp.out_ip == 32'd0)
            && (!rsp.out_port_any || rsp.out_port == 16'd0))
        else $error("wildcard translation with nonzero value");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg == 2'd0 |-> !rsp_valid)
        else $error("result without an accepted item");

    a_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg >= 2'd2 |-> req_stall)
        else $error("item accepted with two results pending");

endmodule

bind wildcard_nat_rule_lookup wnrl_checker u_wnrl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

@@ test/wildcard_nat_rule_lookup_tb.sv @@
`timescale 1ns / 1ps

module wildcard_nat_rule_lookup_tb;

    localparam int DEPTH = wnrl_pkg::RULE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = DEPTH + 40;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] FN_RESERVED = 2'd3;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    wnrl_pkg::req_t req_item = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    wnrl_pkg::rsp_t rsp_item;

    // shadow of the rule table
    wnrl_pkg::entry_t table_keys [DEPTH];
    wnrl_pkg::entry_t table_xlats [DEPTH];
    int table_used = 0;

    wnrl_pkg::rsp_t awaited_rsp [$];
    int items_sent = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    logic [31:0] ip_pool [4];
    logic [15:0] port_pool [4];

    wildcard_nat_rule_lookup #(
        .RULE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp_item)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic wnrl_pkg::entry_t pack_pair(input logic [31:0] ip, input logic ip_any,
                                                   input logic [15:0] port,
                                                   input logic port_any);
        wnrl_pkg::entry_t e;
        e.ip_any = ip_any;
        e.ip = ip_any ? 32'd0 : ip;
        e.port_any = port_any;
        e.port = port_any ? 16'd0 : port;
        return e;
    endfunction

    // applies one item to the shadow table and returns the answer it should give
    function automatic wnrl_pkg::rsp_t nat_table_apply(input wnrl_pkg::req_t r);
        wnrl_pkg::rsp_t res;
        int i;
        logic found;
        res = '0;
        res.status = wnrl_pkg::ST_MISS;
        found = 1'b0;
        case (r.func)
            wnrl_pkg::FN_APPEND:
            begin
                if (table_used >= DEPTH)
                begin
                    res.status = wnrl_pkg::ST_FULL;
                end
                else
                begin
                    table_keys[table_used] = pack_pair(r.key_ip, r.key_ip_any,
                                                       r.key_port, r.key_port_any);
                    table_xlats[table_used] = pack_pair(r.xlat_ip, r.xlat_ip_any,
                                                        r.xlat_port, r.xlat_port_any);
                    table_used++;
                    res.status = wnrl_pkg::ST_STORED;
                end
            end
            wnrl_pkg::FN_LOOKUP:
            begin
                for (i = 0; i < table_used && !found; i++)
                begin
                    if ((table_keys[i].ip_any || table_keys[i].ip == r.key_ip) &&
                        (table_keys[i].port_any || table_keys[i].port == r.key_port))
                    begin
                        found = 1'b1;
                        res.status = wnrl_pkg::ST_HIT;
                        res.out_ip = table_xlats[i].ip;
                        res.out_ip_any = table_xlats[i].ip_any;
                        res.out_port = table_xlats[i].port;
                        res.out_port_any = table_xlats[i].port_any;
                    end
                end
            end
            wnrl_pkg::FN_CLEAR:
            begin
                table_used = 0;
                res.status = wnrl_pkg::ST_CLEARED;
            end
            default:
            begin
                res.status = wnrl_pkg::ST_MISS;
            end
        endcase
        return res;
    endfunction

    function automatic wnrl_pkg::req_t random_req();
        wnrl_pkg::req_t r;
        r.func = wnrl_pkg::func_t'($urandom_range(3));
        r.key_ip = $urandom;
        r.key_ip_any = 1'($urandom_range(1));
        r.key_port = 16'($urandom_range(16'hffff));
        r.key_port_any = 1'($urandom_range(1));
        r.xlat_ip = $urandom;
        r.xlat_ip_any = 1'($urandom_range(1));
        r.xlat_port = 16'($urandom_range(16'hffff));
        r.xlat_port_any = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic wnrl_pkg::req_t append_req(input logic [31:0] kip, input logic kia,
                                                  input logic [15:0] kport, input logic kpa,
                                                  input logic [31:0] xip, input logic xia,
                                                  input logic [15:0] xport, input logic xpa);
        wnrl_pkg::req_t r;
        r.func = wnrl_pkg::FN_APPEND;
        r.key_ip = kip;
        r.key_ip_any = kia;
        r.key_port = kport;
        r.key_port_any = kpa;
        r.xlat_ip = xip;
        r.xlat_ip_any = xia;
        r.xlat_port = xport;
        r.xlat_port_any = xpa;
        return r;
    endfunction

    // unused fields carry noise, the block has to ignore them
    function automatic wnrl_pkg::req_t lookup_req(input logic [31:0] ip,
                                                  input logic [15:0] port);
        wnrl_pkg::req_t r;
        r = random_req();
        r.func = wnrl_pkg::FN_LOOKUP;
        r.key_ip = ip;
        r.key_port = port;
        return r;
    endfunction

    function automatic wnrl_pkg::req_t clear_req();
        wnrl_pkg::req_t r;
        r = random_req();
        r.func = wnrl_pkg::FN_CLEAR;
        return r;
    endfunction

    // keys drawn from small pools so that rules overlap and priority matters
    function automatic wnrl_pkg::req_t random_rule();
        logic [31:0] kip;
        logic [15:0] kport;
        kip = ($urandom_range(1) == 1) ? ip_pool[2'($urandom_range(3))] : $urandom;
        kport = ($urandom_range(1) == 1) ? port_pool[2'($urandom_range(3))]
                                         : 16'($urandom_range(16'hffff));
        return append_req(kip, $urandom_range(99) < 20, kport, $urandom_range(99) < 20,
                          $urandom, $urandom_range(99) < 15,
                          16'($urandom_range(16'hffff)), $urandom_range(99) < 15);
    endfunction

    // mostly keys of stored rules, some one bit off, the rest from the pools or random
    function automatic wnrl_pkg::req_t probe_req();
        logic [31:0] ip;
        logic [15:0] port;
        int pick;
        int k;
        k = $urandom_range(99);
        ip = ($urandom_range(1) == 1) ? ip_pool[2'($urandom_range(3))] : $urandom;
        port = ($urandom_range(1) == 1) ? port_pool[2'($urandom_range(3))]
                                        : 16'($urandom_range(16'hffff));
        if (table_used > 0 && k < 85)
        begin
            pick = $urandom_range(table_used - 1);
            if (!table_keys[pick].ip_any)
                ip = table_keys[pick].ip;
            if (!table_keys[pick].port_any)
                port = table_keys[pick].port;
            if (k >= 70)
            begin
                if ($urandom_range(1) == 1)
                    ip = ip ^ (32'd1 << $urandom_range(31));
                else
                    port = port ^ (16'd1 << $urandom_range(15));
            end
        end
        return lookup_req(ip, port);
    endfunction

    task automatic send_req(input wnrl_pkg::req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        awaited_rsp.push_back(nat_table_apply(item));
        items_sent++;
    endtask

    task automatic flag_result(input string why, input wnrl_pkg::rsp_t want,
                               input wnrl_pkg::rsp_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t %s: expected status %0d ip %h/%b port %h/%b",
                     $time, why, want.status, want.out_ip, want.out_ip_any, want.out_port,
                     want.out_port_any);
            $display("    got status %0d ip %h/%b port %h/%b",
                     got.status, got.out_ip, got.out_ip_any, got.out_port, got.out_port_any);
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        wnrl_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    flag_result("unexpected result", '0, rsp_item);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp_item.status !== want.status || rsp_item.out_ip !== want.out_ip ||
                        rsp_item.out_ip_any !== want.out_ip_any ||
                        rsp_item.out_port !== want.out_port ||
                        rsp_item.out_port_any !== want.out_port_any)
                        flag_result("mismatch", want, rsp_item);
                end
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        wnrl_pkg::req_t r;
        send_req(clear_req());
        send_req(lookup_req(32'd0, 16'd0));
        send_req(append_req(32'd0, 1'b0, 16'd0, 1'b0, 32'hffffffff, 1'b0, 16'hffff, 1'b0));
        send_req(append_req(32'hffffffff, 1'b0, 16'hffff, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0));
        // same key twice, the earlier rule must win
        send_req(append_req(32'h0a000001, 1'b0, 16'd80, 1'b0, 32'hc0a80001, 1'b0, 16'd8080, 1'b0));
        send_req(append_req(32'h0a000001, 1'b0, 16'd80, 1'b0, 32'hc0a80002, 1'b0, 16'd9090, 1'b0));
        // wildcard parts given with nonzero values, stored as zero
        send_req(append_req(32'h7f7f7f7f, 1'b1, 16'd443, 1'b0, 32'h12345678, 1'b1, 16'd1000, 1'b0));
        send_req(append_req(32'h01020304, 1'b0, 16'h5a5a, 1'b1, 32'h05060708, 1'b0, 16'habcd, 1'b1));
        send_req(lookup_req(32'd0, 16'd0));
        send_req(lookup_req(32'hffffffff, 16'hffff));
        send_req(lookup_req(32'h0a000001, 16'd80));
        send_req(lookup_req($urandom, 16'd443));
        send_req(lookup_req(32'h01020304, 16'($urandom_range(16'hffff))));
        // wildcard flags on a lookup are not honored
        r = lookup_req(32'h99999999, 16'd5);
        r.key_ip_any = 1'b1;
        r.key_port_any = 1'b1;
        send_req(r);
        r = random_req();
        r.func = wnrl_pkg::func_t'(FN_RESERVED);
        send_req(r);
        send_req(append_req(32'hffffffff, 1'b1, 16'hffff, 1'b1, 32'h11111111, 1'b0, 16'h2222, 1'b0));
        send_req(lookup_req($urandom, 16'($urandom_range(16'hffff))));
        r = append_req(32'hffffffff, 1'b1, 16'hffff, 1'b1, 32'hffffffff, 1'b1, 16'hffff, 1'b1);
        r.func = wnrl_pkg::FN_CLEAR;
        send_req(r);
        send_req(lookup_req(32'd0, 16'd0));
        send_req(append_req(32'hc0000201, 1'b0, 16'd53, 1'b0, 32'h08080808, 1'b0, 16'd53, 1'b0));
        send_req(lookup_req(32'hc0000201, 16'd53));
    endtask

    task automatic test_full_table();
        send_req(clear_req());
        repeat (DEPTH - 1)
            send_req(append_req($urandom, 1'b0, 16'($urandom_range(16'hffff)), 1'b0,
                                $urandom, 1'($urandom_range(1)),
                                16'($urandom_range(16'hffff)), 1'($urandom_range(1))));
        send_req(append_req(32'hdeadbeef, 1'b0, 16'h1234, 1'b0, 32'hcafef00d, 1'b0, 16'h4321, 1'b0));
        send_req(random_rule());
        send_req(random_rule());
        // last slot has to be reachable
        send_req(lookup_req(32'hdeadbeef, 16'h1234));
        send_req(lookup_req(32'hdeadbeef, 16'h1235));
        send_req(clear_req());
        send_req(random_rule());
        send_req(probe_req());
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        int saved_idle;
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        hold_request = HOLD_CYCLES;
        send_req(clear_req());
        repeat (30)
            send_req(random_rule());
        repeat (4)
            send_req(probe_req());
        send_idle_pct = saved_idle;
    endtask

    task automatic test_random_traffic(input int n_items);
        int target;
        int n_rules;
        int k;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_req(random_req());
            end
            else
            begin
                if ($urandom_range(99) < 60)
                    send_req(clear_req());
                k = $urandom_range(99);
                if (k < 91)
                    n_rules = $urandom_range(1, 10);
                else if (k < 99)
                    n_rules = $urandom_range(11, 40);
                else
                    n_rules = DEPTH + 4;
                repeat (n_rules)
                    send_req(random_rule());
                repeat ($urandom_range(1, 5))
                    send_req(probe_req());
            end
        end
    endtask

    initial
    begin
        ip_pool[0] = 32'd0;
        ip_pool[1] = 32'hffffffff;
        ip_pool[2] = $urandom;
        ip_pool[3] = $urandom;
        port_pool[0] = 16'd0;
        port_pool[1] = 16'hffff;
        port_pool[2] = 16'($urandom_range(16'hffff));
        port_pool[3] = 16'($urandom_range(16'hffff));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        recv_stall_pct = 71;
        test_directed();
        test_full_table();
        test_backpressure();
        test_random_traffic(310);

        send_idle_pct = 71;
        recv_stall_pct = 10;
        test_random_traffic(310);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_traffic(310);

        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
